### src/bse_pkg.sv
package bse_pkg;

  localparam int unsigned WordCount   = 64;
  localparam int unsigned BitsPerWord = 32;
  localparam int unsigned CmdW        = 3;
  localparam int unsigned ValueW      = 12;
  localparam int unsigned FoundW      = 11;
  localparam int unsigned TotalW      = 12;
  localparam int unsigned BitW        = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_TEST   = 3'd2,
    CMD_COUNT  = 3'd3,
    CMD_FIND   = 3'd4,
    CMD_CLEAR  = 3'd5,
    CMD_EMPTY  = 3'd6,
    CMD_NONE   = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_MODIFY,
    BK_SCAN,
    BK_WIPE,
    BK_DONE
  } back_state_e;

  // classified command word passed through the queue
  typedef struct packed {
    cmd_e             cmd;
    logic             in_range;
    logic [ValueW-1:0] value;
  } item_t;

  // lowest set bit of a word
  function automatic logic [BitW-1:0] lowest_bit(input logic [BitsPerWord-1:0] w);
    logic [BitW-1:0] r;
    r = '0;
    for (int i = BitsPerWord - 1; i >= 0; i--) begin
      if (w[i]) r = BitW'(i);
    end
    return r;
  endfunction

endpackage

### src/bse_ram.sv
module bse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/bse_front.sv
module bse_front #(
  parameter int unsigned WordCount = bse_pkg::WordCount
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bse_pkg::CmdW-1:0]    command_i,
  input  logic [bse_pkg::ValueW-1:0]  value_i,
  output logic                        busy_o,
  output logic                        q_valid_o,
  output bse_pkg::item_t              q_item_o,
  input  logic                        q_pop_i
);

  localparam int unsigned CapBits = $clog2(WordCount * bse_pkg::BitsPerWord + 1);
  localparam logic [CapBits-1:0] Capacity = CapBits'(WordCount * bse_pkg::BitsPerWord);

  // two-entry queue
  bse_pkg::item_t ent_q [2];
  logic           rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [1:0]     fill_q, fill_d;
  logic           push;
  bse_pkg::item_t item;
  logic [CapBits:0] val_ext;

  // classify: range check against capacity
  always_comb begin
    val_ext       = (CapBits + 1)'(value_i);
    item.cmd      = bse_pkg::cmd_e'(command_i);
    item.value    = value_i;
    item.in_range = (val_ext < {1'b0, Capacity});
  end

  // the block takes one command at a time
  assign busy_o    = (fill_q != 2'd0) || q_pop_i;
  assign push      = start_i && !busy_o;
  assign q_valid_o = (fill_q != 2'd0);
  assign q_item_o  = ent_q[rd_ptr_q];

  always_comb begin
    rd_ptr_d = rd_ptr_q ^ q_pop_i;
    wr_ptr_d = wr_ptr_q ^ push;
    fill_d   = fill_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_ptr_q] <= item;
  end

endmodule

### src/bse_back.sv
module bse_back #(
  parameter int unsigned WordCount = bse_pkg::WordCount
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  bse_pkg::item_t                q_item_i,
  output logic                          q_pop_o,
  output logic                          done_o,
  output logic                          status_o,
  output logic                          hit_o,
  output logic [bse_pkg::FoundW-1:0]    found_value_o,
  output logic [bse_pkg::TotalW-1:0]    member_total_o
);

  localparam int unsigned AddrW = (WordCount > 1) ? $clog2(WordCount) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(WordCount - 1);
  localparam int unsigned FullW = AddrW + bse_pkg::BitW;

  bse_pkg::back_state_e state_q, state_d;
  bse_pkg::item_t       cur_q, cur_d;
  logic [AddrW-1:0]     addr_q, addr_d;
  logic [bse_pkg::TotalW-1:0] total_q, total_d;
  logic                 hit_q, hit_d, stat_q, stat_d;
  logic [bse_pkg::FoundW-1:0] found_q, found_d;
  logic                 first_q, first_d;
  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr, ram_raddr;
  logic [bse_pkg::BitsPerWord-1:0] ram_wdata, ram_rdata, mask, scan_w;
  logic [AddrW-1:0]     word_idx;
  logic [bse_pkg::BitW-1:0] bit_idx;
  logic [FullW-1:0]     found_full;

  bse_ram #(.Width(bse_pkg::BitsPerWord), .Depth(WordCount)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // split value into word index and bit position
  always_comb begin
    bit_idx  = cur_q.value[bse_pkg::BitW-1:0];
    word_idx = AddrW'(cur_q.value >> bse_pkg::BitW);
    mask     = bse_pkg::BitsPerWord'(1) << bit_idx;
    scan_w   = first_q ? (ram_rdata & ({bse_pkg::BitsPerWord{1'b1}} << bit_idx)) : ram_rdata;
    found_full = {addr_q, bse_pkg::lowest_bit(scan_w)};
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bse_pkg::BK_IDLE: begin
        if (q_valid_i) state_d = bse_pkg::BK_READ;
      end
      bse_pkg::BK_READ: begin
        case (cur_q.cmd)
          bse_pkg::CMD_ADD, bse_pkg::CMD_REMOVE, bse_pkg::CMD_TEST:
            state_d = cur_q.in_range ? bse_pkg::BK_MODIFY : bse_pkg::BK_DONE;
          bse_pkg::CMD_FIND:
            state_d = cur_q.in_range ? bse_pkg::BK_SCAN : bse_pkg::BK_DONE;
          bse_pkg::CMD_CLEAR: state_d = bse_pkg::BK_WIPE;
          default:            state_d = bse_pkg::BK_DONE;
        endcase
      end
      bse_pkg::BK_MODIFY: state_d = bse_pkg::BK_DONE;
      bse_pkg::BK_SCAN: begin
        if (scan_w != '0 || addr_q == LastAddr) state_d = bse_pkg::BK_DONE;
      end
      bse_pkg::BK_WIPE: begin
        if (addr_q == LastAddr) state_d = bse_pkg::BK_DONE;
      end
      bse_pkg::BK_DONE: state_d = bse_pkg::BK_IDLE;
      default:          state_d = bse_pkg::BK_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cur_d     = cur_q;
    addr_d    = addr_q;
    total_d   = total_q;
    hit_d     = hit_q;
    stat_d    = stat_q;
    found_d   = found_q;
    first_d   = first_q;
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = ram_rdata;
    ram_raddr = addr_q;
    case (state_q)
      bse_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_item_i;
          hit_d   = 1'b0;
          stat_d  = 1'b0;
          found_d = '0;
          first_d = 1'b1;
        end
      end
      bse_pkg::BK_READ: begin
        ram_raddr = word_idx;
        addr_d    = word_idx;
        case (cur_q.cmd)
          bse_pkg::CMD_ADD:   stat_d = !cur_q.in_range;
          bse_pkg::CMD_CLEAR: addr_d = '0;
          bse_pkg::CMD_EMPTY: hit_d = (total_q == '0);
          default: ;
        endcase
      end
      bse_pkg::BK_MODIFY: begin
        case (cur_q.cmd)
          bse_pkg::CMD_ADD: begin
            if ((ram_rdata & mask) == '0) begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata | mask;
              total_d   = total_q + 1'b1;
            end
          end
          bse_pkg::CMD_REMOVE: begin
            if ((ram_rdata & mask) != '0) begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata & ~mask;
              total_d   = total_q - 1'b1;
            end
          end
          default: hit_d = ((ram_rdata & mask) != '0);
        endcase
      end
      bse_pkg::BK_SCAN: begin
        // one word per cycle, read of the next word issued ahead
        first_d   = 1'b0;
        ram_raddr = addr_q + 1'b1;
        if (scan_w != '0) begin
          hit_d   = 1'b1;
          found_d = bse_pkg::FoundW'(found_full);
        end else if (addr_q != LastAddr) begin
          addr_d = addr_q + 1'b1;
        end
      end
      bse_pkg::BK_WIPE: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        total_d   = '0;
        addr_d    = addr_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bse_pkg::BK_WIPE;
      addr_q  <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    hit_q   <= hit_d;
    stat_q  <= stat_d;
    found_q <= found_d;
    first_q <= first_d;
  end

  // result word strobe, also raised once at the end of the wipe after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= (state_q == bse_pkg::BK_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    status_o       <= stat_q;
    hit_o          <= hit_q;
    found_value_o  <= found_q;
    member_total_o <= total_q;
  end

endmodule

### src/bitmap_set_engine.sv
// channel | direction | handshake        | words
// command | in        | start, busy      | command_i, value_i
// result  | out       | done_o strobe    | status_o, hit_o, found_value_o, member_total_o
//
// add, remove, test: done_o follows the read, modify and done states; count, is-empty,
// unused code, out-of-range skip modify. the next word is taken the cycle after done_o.
// find next: one word scanned at a time, set by the single RAM read port.
// clear all: every word is zeroed, one word written per cycle.
// after reset a clearing pass runs over every word; busy stays high.
// a result shows for one cycle and cannot be stalled.
module bitmap_set_engine #(
  parameter int unsigned WordCount = bse_pkg::WordCount
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [bse_pkg::CmdW-1:0]    command_i,
  input  logic [bse_pkg::ValueW-1:0]  value_i,
  output logic                        done_o,
  output logic                        status_o,
  output logic                        hit_o,
  output logic [bse_pkg::FoundW-1:0]  found_value_o,
  output logic [bse_pkg::TotalW-1:0]  member_total_o
);

  logic           q_valid, q_pop, f_busy, reset_wipe_q, back_done;
  bse_pkg::item_t q_item;

  bse_front #(.WordCount(WordCount)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start && !busy),
    .command_i(command_i),
    .value_i  (value_i),
    .busy_o   (f_busy),
    .q_valid_o(q_valid),
    .q_item_o (q_item),
    .q_pop_i  (q_pop)
  );

  bse_back #(.WordCount(WordCount)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .done_o        (back_done),
    .status_o      (status_o),
    .hit_o         (hit_o),
    .found_value_o (found_value_o),
    .member_total_o(member_total_o)
  );

  // hold off commands until the post-reset wipe and its stray strobe pass
  logic busy_hold_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_wipe_q <= 1'b1;
      busy_hold_q  <= 1'b0;
    end else begin
      if (back_done) reset_wipe_q <= 1'b0;
      busy_hold_q <= q_pop || q_valid || busy_hold_q && !back_done;
    end
  end

  // the strobe that ends the post-reset wipe carries no result
  assign done_o = back_done && !reset_wipe_q;
  assign busy   = reset_wipe_q || f_busy || busy_hold_q;

endmodule

### src/bse_checker.sv
module bse_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input logic                        status_o,
  input logic                        hit_o,
  input logic [bse_pkg::FoundW-1:0]  found_value_o,
  input logic [bse_pkg::TotalW-1:0]  member_total_o
);

  // a strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done strobe held");

  // an accepted command makes the block busy
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("not busy after accept");

  // no result while idle and not busy
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without command");

  // overflow status implies no hit
  a_stat_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> !hit_o) else $error("status and hit");

endmodule

bind bitmap_set_engine bse_checker u_bse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .hit_o         (hit_o),
  .found_value_o (found_value_o),
  .member_total_o(member_total_o)
);
